[hdl/kbd_pkg.sv]
`timescale 1ns / 1ps
package kbd_pkg;

  localparam int NUM_CODES      = 128;
  localparam int CODE_W         = $clog2(NUM_CODES);
  localparam int NUM_TABLES     = 3;
  localparam int TSEL_W         = 2;
  localparam int DEF_CHAR_WIDTH = 16;
  localparam int OUT_CHAR_W     = 16;
  localparam int SPECIAL_W      = 8;
  localparam int MOD_W          = 6;
  localparam int LOCK_W         = 3;

  localparam logic [TSEL_W-1:0] TBL_GENERAL = 2'd0;
  localparam logic [TSEL_W-1:0] TBL_SHIFT   = 2'd1;
  localparam logic [TSEL_W-1:0] TBL_ALT     = 2'd2;

  localparam logic [7:0] BYTE_ACK    = 8'hFA;
  localparam logic [7:0] BYTE_RESEND = 8'hFE;

  localparam logic [CODE_W-1:0] KEY_LSHIFT = 7'h2A;
  localparam logic [CODE_W-1:0] KEY_RSHIFT = 7'h36;
  localparam logic [CODE_W-1:0] KEY_LALT   = 7'h38;
  localparam logic [CODE_W-1:0] KEY_RALT   = 7'h64;
  localparam logic [CODE_W-1:0] KEY_LCTRL  = 7'h1D;
  localparam logic [CODE_W-1:0] KEY_RCTRL  = 7'h61;
  localparam logic [CODE_W-1:0] KEY_CAPS   = 7'h3A;
  localparam logic [CODE_W-1:0] KEY_NUM    = 7'h45;
  localparam logic [CODE_W-1:0] KEY_SCROLL = 7'h46;

  localparam logic [MOD_W-1:0] MOD_LSHIFT = 6'h01;
  localparam logic [MOD_W-1:0] MOD_RSHIFT = 6'h02;
  localparam logic [MOD_W-1:0] MOD_LALT   = 6'h04;
  localparam logic [MOD_W-1:0] MOD_RALT   = 6'h08;
  localparam logic [MOD_W-1:0] MOD_LCTRL  = 6'h10;
  localparam logic [MOD_W-1:0] MOD_RCTRL  = 6'h20;
  localparam logic [MOD_W-1:0] MOD_NONE   = 6'h00;

  localparam logic [LOCK_W-1:0] LOCK_SCROLL = 3'h1;
  localparam logic [LOCK_W-1:0] LOCK_NUM    = 3'h2;
  localparam logic [LOCK_W-1:0] LOCK_CAPS   = 3'h4;
  localparam logic [LOCK_W-1:0] LOCK_NONE   = 3'h0;

  typedef enum logic [1:0] {
    ACT_SCAN,
    ACT_LOAD_CHAR,
    ACT_LOAD_SPECIAL,
    ACT_COMMAND
  } action_t;

  typedef enum logic [1:0] {
    REPLY_NONE,
    REPLY_ACK_SEEN,
    REPLY_RESEND_SEEN
  } reply_t;

  typedef struct packed {
    logic              event_valid;
    reply_t            reply;
    logic              key_down;
    logic              xlate;
    logic [MOD_W-1:0]  mods;
    logic [LOCK_W-1:0] locks;
  } kbd_info_t;

  function automatic logic [LOCK_W-1:0] lock_bit(input logic [CODE_W-1:0] code);
    logic [LOCK_W-1:0] r;
    r = LOCK_NONE;
    if (code == KEY_CAPS) r = LOCK_CAPS;
    else if (code == KEY_NUM) r = LOCK_NUM;
    else if (code == KEY_SCROLL) r = LOCK_SCROLL;
    return r;
  endfunction

  function automatic logic [MOD_W-1:0] modifier_bit(input logic [CODE_W-1:0] code);
    logic [MOD_W-1:0] r;
    r = MOD_NONE;
    if (code == KEY_LSHIFT) r = MOD_LSHIFT;
    else if (code == KEY_RSHIFT) r = MOD_RSHIFT;
    else if (code == KEY_LALT) r = MOD_LALT;
    else if (code == KEY_RALT) r = MOD_RALT;
    else if (code == KEY_LCTRL) r = MOD_LCTRL;
    else if (code == KEY_RCTRL) r = MOD_RCTRL;
    return r;
  endfunction

endpackage

[hdl/kbd_ram.sv]
`timescale 1ns / 1ps
module kbd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/kbd_decode.sv]
`timescale 1ns / 1ps
module kbd_decode import kbd_pkg::*; #(
  parameter int CHAR_WIDTH = DEF_CHAR_WIDTH,
  localparam int CADDR_W = $clog2(NUM_TABLES * NUM_CODES)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic [1:0]            action,
  input  logic [7:0]            scan_byte,
  input  logic [TSEL_W-1:0]     table_select,
  input  logic [CODE_W-1:0]     table_index,
  input  logic [15:0]           table_value,
  output kbd_info_t             info,
  output logic                  char_we,
  output logic [CADDR_W-1:0]    char_waddr,
  output logic [CHAR_WIDTH-1:0] char_wdata,
  output logic [CADDR_W-1:0]    char_raddr,
  output logic                  sp_we,
  output logic [CODE_W-1:0]     sp_waddr,
  output logic [SPECIAL_W-1:0]  sp_wdata,
  output logic [CODE_W-1:0]     sp_raddr
);

  logic [MOD_W-1:0]  mods, mods_next;
  logic [LOCK_W-1:0] locks, locks_next;
  logic              pending, pending_next;

  logic [CODE_W-1:0] code;
  logic              release_key;
  logic [LOCK_W-1:0] lb;
  logic [MOD_W-1:0]  mb;
  logic [TSEL_W-1:0] rd_tsel;
  action_t           act;

  assign act         = action_t'(action);
  assign code        = scan_byte[CODE_W-1:0];
  assign release_key = scan_byte[7];
  assign lb          = lock_bit(code);
  assign mb          = modifier_bit(code);

  // shift/caps -> shift table, RALT -> alt, else general
  always_comb begin
    if (((mods & (MOD_LSHIFT | MOD_RSHIFT)) != MOD_NONE) || ((locks & LOCK_CAPS) != LOCK_NONE)) begin
      rd_tsel = TBL_SHIFT;
    end else if ((mods & MOD_RALT) != MOD_NONE) begin
      rd_tsel = TBL_ALT;
    end else begin
      rd_tsel = TBL_GENERAL;
    end
  end

  assign char_raddr = CADDR_W'({rd_tsel, code});
  assign sp_raddr   = code;

  assign char_we    = accept && (act == ACT_LOAD_CHAR) && (table_select <= TBL_ALT);
  assign char_waddr = CADDR_W'({table_select, table_index});
  assign char_wdata = CHAR_WIDTH'(table_value);
  assign sp_we      = accept && (act == ACT_LOAD_SPECIAL);
  assign sp_waddr   = table_index;
  assign sp_wdata   = table_value[SPECIAL_W-1:0];

  always_comb begin
    mods_next        = mods;
    locks_next       = locks;
    pending_next     = pending;
    info             = '0;
    info.reply       = REPLY_NONE;
    unique case (act)
      ACT_LOAD_CHAR, ACT_LOAD_SPECIAL: begin
      end
      ACT_COMMAND: begin
        pending_next = 1'b1;
      end
      ACT_SCAN: begin
        priority if (pending && scan_byte == BYTE_ACK) begin
          pending_next = 1'b0;
          info.reply   = REPLY_ACK_SEEN;
        end else if (pending && scan_byte == BYTE_RESEND) begin
          pending_next = 1'b0;
          info.reply   = REPLY_RESEND_SEEN;
        end else begin
          info.event_valid = 1'b1;
          if (!release_key) begin
            info.key_down = 1'b1;
            if (lb != LOCK_NONE) begin
              locks_next = locks ^ lb;
            end else if (mb != MOD_NONE) begin
              mods_next = mods | mb;
            end else begin
              info.xlate = 1'b1;
            end
          end else begin
            if (mb != MOD_NONE) begin
              mods_next = mods & ~mb;
            end else begin
              info.xlate = 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase
    info.mods  = mods_next;
    info.locks = locks_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mods    <= MOD_NONE;
      locks   <= LOCK_NONE;
      pending <= 1'b0;
    end else if (accept) begin
      mods    <= mods_next;
      locks   <= locks_next;
      pending <= pending_next;
    end
  end

endmodule

[hdl/kbd_resolve.sv]
`timescale 1ns / 1ps
module kbd_resolve import kbd_pkg::*; #(
  parameter int CHAR_WIDTH = DEF_CHAR_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  kbd_info_t             info,
  output logic                  take,
  input  logic [CHAR_WIDTH-1:0] char_rdata,
  input  logic [SPECIAL_W-1:0]  sp_rdata,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  event_valid,
  output logic [1:0]            reply_seen,
  output logic                  key_down,
  output logic                  has_character,
  output logic [OUT_CHAR_W-1:0] character,
  output logic                  has_special,
  output logic [SPECIAL_W-1:0]  special_code,
  output logic [MOD_W-1:0]      modifier_flags,
  output logic [LOCK_W-1:0]     lock_leds
);

  logic      s1_valid;
  kbd_info_t s1_info;
  logic      advance;
  logic      ch_zero;

  // RAM data lines up with s1; no read is issued while s1 holds
  assign advance = s1_valid && (!out_valid || !out_stall);
  assign take    = !s1_valid || advance;
  assign ch_zero = (char_rdata == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_info <= info;
    end
    if (advance) begin
      event_valid    <= s1_info.event_valid;
      reply_seen     <= s1_info.reply;
      key_down       <= s1_info.key_down;
      has_character  <= s1_info.xlate && !ch_zero;
      character      <= (s1_info.xlate && !ch_zero) ? OUT_CHAR_W'(char_rdata) : '0;
      has_special    <= s1_info.xlate && ch_zero;
      special_code   <= (s1_info.xlate && ch_zero) ? sp_rdata : '0;
      modifier_flags <= s1_info.mods;
      lock_leds      <= s1_info.locks;
    end
  end

endmodule

[hdl/keyboard_scancode_decoder.sv]
`timescale 1ns / 1ps
// channel  dir  handshake             payload
// in       in   in_valid / in_stall   action, scan_byte, table_select, table_index, table_value
// out      out  out_valid / out_stall event_valid, reply_seen, key_down, has_character,
//                                     character, has_special, special_code, modifier_flags,
//                                     lock_leds
// One transaction per cycle while in_stall is low. The result is registered by the
// read of the character and special-key RAMs, alongside the s1 info register,
// and then by the output register.
// rst clears modifier, lock and reply state; table RAMs are not cleared.
// out_stall holds the output register, then the RAM stage, then in_stall rises.
module keyboard_scancode_decoder import kbd_pkg::*; #(
  parameter int CHAR_WIDTH = DEF_CHAR_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            action,
  input  logic [7:0]            scan_byte,
  input  logic [TSEL_W-1:0]     table_select,
  input  logic [CODE_W-1:0]     table_index,
  input  logic [15:0]           table_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  event_valid,
  output logic [1:0]            reply_seen,
  output logic                  key_down,
  output logic                  has_character,
  output logic [OUT_CHAR_W-1:0] character,
  output logic                  has_special,
  output logic [SPECIAL_W-1:0]  special_code,
  output logic [MOD_W-1:0]      modifier_flags,
  output logic [LOCK_W-1:0]     lock_leds
);

  localparam int CDEPTH  = NUM_TABLES * NUM_CODES;
  localparam int CADDR_W = $clog2(CDEPTH);

  logic                  take;
  logic                  accept;
  kbd_info_t             info;
  logic                  char_we;
  logic [CADDR_W-1:0]    char_waddr;
  logic [CHAR_WIDTH-1:0] char_wdata;
  logic [CADDR_W-1:0]    char_raddr;
  logic [CHAR_WIDTH-1:0] char_rdata;
  logic                  sp_we;
  logic [CODE_W-1:0]     sp_waddr;
  logic [SPECIAL_W-1:0]  sp_wdata;
  logic [CODE_W-1:0]     sp_raddr;
  logic [SPECIAL_W-1:0]  sp_rdata;

  assign in_stall = !take;
  assign accept   = in_valid && take;

  kbd_decode #(.CHAR_WIDTH(CHAR_WIDTH)) u_decode (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .action       (action),
    .scan_byte    (scan_byte),
    .table_select (table_select),
    .table_index  (table_index),
    .table_value  (table_value),
    .info         (info),
    .char_we      (char_we),
    .char_waddr   (char_waddr),
    .char_wdata   (char_wdata),
    .char_raddr   (char_raddr),
    .sp_we        (sp_we),
    .sp_waddr     (sp_waddr),
    .sp_wdata     (sp_wdata),
    .sp_raddr     (sp_raddr)
  );

  kbd_ram #(.WIDTH(CHAR_WIDTH), .DEPTH(CDEPTH)) u_char_ram (
    .clk   (clk),
    .we    (char_we),
    .waddr (char_waddr),
    .wdata (char_wdata),
    .re    (accept),
    .raddr (char_raddr),
    .rdata (char_rdata)
  );

  kbd_ram #(.WIDTH(SPECIAL_W), .DEPTH(NUM_CODES)) u_special_ram (
    .clk   (clk),
    .we    (sp_we),
    .waddr (sp_waddr),
    .wdata (sp_wdata),
    .re    (accept),
    .raddr (sp_raddr),
    .rdata (sp_rdata)
  );

  kbd_resolve #(.CHAR_WIDTH(CHAR_WIDTH)) u_resolve (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .info           (info),
    .take           (take),
    .char_rdata     (char_rdata),
    .sp_rdata       (sp_rdata),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .event_valid    (event_valid),
    .reply_seen     (reply_seen),
    .key_down       (key_down),
    .has_character  (has_character),
    .character      (character),
    .has_special    (has_special),
    .special_code   (special_code),
    .modifier_flags (modifier_flags),
    .lock_leds      (lock_leds)
  );

endmodule

[hdl/kbd_check.sv]
`timescale 1ns / 1ps
module kbd_check import kbd_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic                  event_valid,
  input logic [1:0]            reply_seen,
  input logic                  key_down,
  input logic                  has_character,
  input logic                  has_special,
  input logic [SPECIAL_W-1:0]  special_code,
  input logic [MOD_W-1:0]      modifier_flags,
  input logic [LOCK_W-1:0]     lock_leds
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(modifier_flags) && $stable(lock_leds))
    else $error("output transaction dropped while stalled");

  a_no_event_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && !event_valid |-> !key_down && !has_character && !has_special
                                  && special_code == '0)
    else $error("event fields set without an event");

  a_one_translation: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(has_character && has_special))
    else $error("both character and special key flagged");

  a_reply_no_event: assert property (@(posedge clk) disable iff (rst)
    out_valid && reply_seen != REPLY_NONE |-> !event_valid)
    else $error("reply consumed but event reported");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty output");

endmodule

bind keyboard_scancode_decoder kbd_check u_check (.*);
